// ----- hw/rtl/ibd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ibd_pkg;

    // debounced status codes
    localparam logic [1:0] ST_OFF     = 2'd0;
    localparam logic [1:0] ST_ON      = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // register word indexes (paddr[4:2])
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_STEP_SIZE      = 3'd0;
    localparam logic [2:0] REG_ACTIVE_HIGH    = 3'd1;
    localparam logic [2:0] REG_LEVEL_FLOOR    = 3'd2;
    localparam logic [2:0] REG_LEVEL_CEILING  = 3'd3;
    localparam logic [2:0] REG_RISE_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_FALL_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_SCAN_INTERVAL  = 3'd6;

    localparam logic [6:0] STEP_MIN = 7'd5;
    localparam logic [6:0] STEP_MAX = 7'd64;

    typedef struct packed {
        logic [6:0] step_size;
        logic       active_high;
        logic [7:0] level_floor;
        logic [7:0] level_ceiling;
        logic [7:0] rise_threshold;
        logic [7:0] fall_threshold;
        logic [7:0] scan_interval;
    } ibd_cfg_t;

    typedef struct packed {
        logic [7:0]  integrator;
        logic [1:0]  status;
        logic [31:0] last_scan_ms;
        logic [31:0] last_press_ms;
        logic [31:0] last_release_ms;
    } ibd_state_t;

    typedef struct packed {
        logic scanned;
        logic press;
        logic release_evt;
    } ibd_event_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ibd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ibd_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        pin_level;
    logic [2:0]  history_slot;

    modport source (output valid, output now_ms, output pin_level, output history_slot,
                    input ready);
    modport sink   (input valid, input now_ms, input pin_level, input history_slot,
                    output ready);
endinterface

interface ibd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  switch_status;
    logic        scanned;
    logic [7:0]  level_now;
    logic [31:0] press_time_ms;
    logic [31:0] release_time_ms;
    logic [2:0]  ring_next;
    logic [31:0] slot_press_ms;
    logic [31:0] slot_release_ms;

    modport source (output valid, output switch_status, output scanned, output level_now,
                    output press_time_ms, output release_time_ms, output ring_next,
                    output slot_press_ms, output slot_release_ms, input ready);
    modport sink   (input valid, input switch_status, input scanned, input level_now,
                    input press_time_ms, input release_time_ms, input ring_next,
                    input slot_press_ms, input slot_release_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/integrating_button_debouncer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Word
// tick     in   valid/ready    now_ms, pin_level, history_slot
// result   out  valid/ready    switch_status, scanned, level_now, press/release times,
//                              ring_next, slot_press_ms, slot_release_ms
// cfg      in   APB write      seven registers at 4*i, pready always high
//
// One word per cycle while the result is not stalled; a word passes the input register, then the result register.
// The integrator, status and history update in a single pass between the two registers.
// Reset puts the state, the valid flags and the history ring to their initial values at once.
// A stalled result holds the pipe; the input register still takes a word while it is empty.

module integrating_button_debouncer #(
    parameter int unsigned HISTORY_DEPTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ibd_tick_if.sink                        tick,
    ibd_result_if.source                    result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ibd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

    ibd_pkg::ibd_cfg_t   cfg;
    ibd_pkg::ibd_state_t state_reg;
    ibd_pkg::ibd_state_t state_next;
    ibd_pkg::ibd_event_t evt;

    logic             in_valid_reg;
    logic [31:0]      in_now_reg;
    logic             in_pin_reg;
    logic [2:0]       in_slot_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             proc;

    logic [IDX_W-1:0] ring_idx_reg;
    logic [IDX_W-1:0] ring_idx_adv;
    logic [IDX_W-1:0] ring_idx_next;
    logic [IDX_W+2:0] ring_wide;
    logic [31:0]      slot_press;
    logic [31:0]      slot_release;

    logic [1:0]       status_reg;
    logic             scanned_reg;
    logic [7:0]       level_reg;
    logic [31:0]      press_time_reg;
    logic [31:0]      release_time_reg;
    logic [2:0]       ring_next_reg;
    logic [31:0]      slot_press_reg;
    logic [31:0]      slot_release_reg;

    ibd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance    = !out_valid_reg || result.ready;
    assign proc       = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_now_reg  <= tick.now_ms;
            in_pin_reg  <= tick.pin_level;
            in_slot_reg <= tick.history_slot;
        end
    end

    ibd_update u_update (
        .cfg        (cfg),
        .state      (state_reg),
        .now_ms     (in_now_reg),
        .pin_level  (in_pin_reg),
        .state_next (state_next),
        .evt        (evt)
    );

    assign ring_idx_adv  = (ring_idx_reg == IDX_LAST) ? '0 : ring_idx_reg + 1'b1;
    assign ring_idx_next = evt.release_evt ? ring_idx_adv : ring_idx_reg;
    assign ring_wide     = {3'b000, ring_idx_next};

    ibd_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (proc),
        .evt             (evt),
        .idx             (ring_idx_reg),
        .idx_adv         (ring_idx_adv),
        .now_ms          (in_now_reg),
        .slot            (in_slot_reg),
        .slot_press_ms   (slot_press),
        .slot_release_ms (slot_release)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.integrator      <= 8'd0;
            state_reg.status          <= ibd_pkg::ST_UNKNOWN;
            state_reg.last_scan_ms    <= 32'd0;
            state_reg.last_press_ms   <= 32'd0;
            state_reg.last_release_ms <= 32'd0;
            ring_idx_reg              <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                state_reg    <= state_next;
                ring_idx_reg <= ring_idx_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            status_reg       <= state_next.status;
            scanned_reg      <= evt.scanned;
            level_reg        <= state_next.integrator;
            press_time_reg   <= state_next.last_press_ms;
            release_time_reg <= state_next.last_release_ms;
            ring_next_reg    <= ring_wide[2:0];
            slot_press_reg   <= slot_press;
            slot_release_reg <= slot_release;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.switch_status   = status_reg;
    assign result.scanned         = scanned_reg;
    assign result.level_now       = level_reg;
    assign result.press_time_ms   = press_time_reg;
    assign result.release_time_ms = release_time_reg;
    assign result.ring_next       = ring_next_reg;
    assign result.slot_press_ms   = slot_press_reg;
    assign result.slot_release_ms = slot_release_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !proc)
        else $error("word processed while result stalled");

    a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(state_reg))
        else $error("debounce state moved without a word");

    a_ring_release: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && evt.release_evt) |=> $stable(ring_idx_reg))
        else $error("ring index moved without a release");

    a_on_not_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status == ibd_pkg::ST_ON |=> state_reg.status != ibd_pkg::ST_UNKNOWN)
        else $error("status fell back to unknown");

    a_event_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc && (evt.press || evt.release_evt) |=> scanned_reg)
        else $error("transition without a scan");

endmodule

`default_nettype wire

// ----- hw/rtl/ibd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ibd_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ibd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output ibd_pkg::ibd_cfg_t              cfg
);

    ibd_pkg::ibd_cfg_t cfg_reg;
    ibd_pkg::ibd_cfg_t cfg_next;
    logic              wr_en;
    logic [6:0]        step_clamped;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        if (pwdata[6:0] < ibd_pkg::STEP_MIN)
        begin
            step_clamped = ibd_pkg::STEP_MIN;
        end
        else if (pwdata[6:0] > ibd_pkg::STEP_MAX)
        begin
            step_clamped = ibd_pkg::STEP_MAX;
        end
        else
        begin
            step_clamped = pwdata[6:0];
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                ibd_pkg::REG_STEP_SIZE:      cfg_next.step_size      = step_clamped;
                ibd_pkg::REG_ACTIVE_HIGH:    cfg_next.active_high    = pwdata[0];
                ibd_pkg::REG_LEVEL_FLOOR:    cfg_next.level_floor    = pwdata[7:0];
                ibd_pkg::REG_LEVEL_CEILING:  cfg_next.level_ceiling  = pwdata[7:0];
                ibd_pkg::REG_RISE_THRESHOLD: cfg_next.rise_threshold = pwdata[7:0];
                ibd_pkg::REG_FALL_THRESHOLD: cfg_next.fall_threshold = pwdata[7:0];
                ibd_pkg::REG_SCAN_INTERVAL:  cfg_next.scan_interval  = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size      <= 7'd16;
            cfg_reg.active_high    <= 1'b0;
            cfg_reg.level_floor    <= 8'd0;
            cfg_reg.level_ceiling  <= 8'd160;
            cfg_reg.rise_threshold <= 8'd120;
            cfg_reg.fall_threshold <= 8'd40;
            cfg_reg.scan_interval  <= 8'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            ibd_pkg::REG_STEP_SIZE:      prdata = {25'd0, cfg_reg.step_size};
            ibd_pkg::REG_ACTIVE_HIGH:    prdata = {31'd0, cfg_reg.active_high};
            ibd_pkg::REG_LEVEL_FLOOR:    prdata = {24'd0, cfg_reg.level_floor};
            ibd_pkg::REG_LEVEL_CEILING:  prdata = {24'd0, cfg_reg.level_ceiling};
            ibd_pkg::REG_RISE_THRESHOLD: prdata = {24'd0, cfg_reg.rise_threshold};
            ibd_pkg::REG_FALL_THRESHOLD: prdata = {24'd0, cfg_reg.fall_threshold};
            ibd_pkg::REG_SCAN_INTERVAL:  prdata = {24'd0, cfg_reg.scan_interval};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibd_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ibd_update (
    input  wire ibd_pkg::ibd_cfg_t   cfg,
    input  wire ibd_pkg::ibd_state_t state,
    input  wire logic [31:0]         now_ms,
    input  wire logic                pin_level,
    output ibd_pkg::ibd_state_t      state_next,
    output ibd_pkg::ibd_event_t      evt
);

    logic [31:0] elapsed;
    logic        scan;
    logic        pressed;
    logic [8:0]  sum_up;
    logic [7:0]  diff_dn;
    logic [7:0]  lvl_up;
    logic [7:0]  lvl_dn;
    logic [7:0]  lvl;

    // elapsed time wraps modulo 2^32
    assign elapsed = now_ms - state.last_scan_ms;
    assign scan    = elapsed > {24'd0, cfg.scan_interval};
    assign pressed = pin_level == cfg.active_high;

    assign sum_up  = {1'b0, state.integrator} + {2'b00, cfg.step_size};
    assign diff_dn = state.integrator - {1'b0, cfg.step_size};
    assign lvl_up  = (sum_up > {1'b0, cfg.level_ceiling}) ? cfg.level_ceiling : sum_up[7:0];
    // a step below zero always lands on the floor
    assign lvl_dn  = (state.integrator < {1'b0, cfg.step_size} ||
                      diff_dn < cfg.level_floor) ? cfg.level_floor : diff_dn;
    assign lvl     = pressed ? lvl_up : lvl_dn;

    always_comb
    begin
        state_next = state;
        evt        = '0;
        if (scan)
        begin
            evt.scanned             = 1'b1;
            state_next.last_scan_ms = now_ms;
            state_next.integrator   = lvl;
            if ((state.status == ibd_pkg::ST_OFF || state.status == ibd_pkg::ST_UNKNOWN) &&
                lvl > cfg.rise_threshold)
            begin
                state_next.status        = ibd_pkg::ST_ON;
                state_next.last_press_ms = now_ms;
                evt.press                = 1'b1;
            end
            else if (state.status == ibd_pkg::ST_ON && lvl < cfg.fall_threshold)
            begin
                state_next.status          = ibd_pkg::ST_OFF;
                state_next.last_release_ms = now_ms;
                evt.release_evt            = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibd_hist.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ibd_hist #(
    parameter int unsigned HISTORY_DEPTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire ibd_pkg::ibd_event_t              evt,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0] idx,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0] idx_adv,
    input  wire logic [31:0]                      now_ms,
    input  wire logic [2:0]                       slot,
    output logic [31:0]                           slot_press_ms,
    output logic [31:0]                           slot_release_ms
);

    localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
    // the slot field reaches eight entries at most; deeper entries are never read back
    localparam int unsigned KEEP  = (HISTORY_DEPTH < 8) ? HISTORY_DEPTH : 8;

    logic [31:0] press_reg    [KEEP];
    logic [31:0] release_reg  [KEEP];
    logic [31:0] press_next   [KEEP];
    logic [31:0] release_next [KEEP];

    always_comb
    begin
        for (int e = 0; e < KEEP; e++)
        begin
            press_next[e]   = press_reg[e];
            release_next[e] = release_reg[e];
            if (en && evt.press && idx == IDX_W'(e))
            begin
                press_next[e] = now_ms;
            end
            if (en && evt.release_evt)
            begin
                if (idx == IDX_W'(e))
                begin
                    release_next[e] = now_ms;
                end
                if (idx_adv == IDX_W'(e))
                begin
                    press_next[e]   = 32'd0;
                    release_next[e] = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < KEEP; e++)
            begin
                press_reg[e]   <= 32'd0;
                release_reg[e] <= 32'd0;
            end
        end
        else
        begin
            for (int e = 0; e < KEEP; e++)
            begin
                press_reg[e]   <= press_next[e];
                release_reg[e] <= release_next[e];
            end
        end
    end

    // read-back shows this word's own writes; slots beyond the ring read as zero
    always_comb
    begin
        slot_press_ms   = 32'd0;
        slot_release_ms = 32'd0;
        for (int e = 0; e < KEEP; e++)
        begin
            if (slot == 3'(e))
            begin
                slot_press_ms   = press_next[e];
                slot_release_ms = release_next[e];
            end
        end
    end

endmodule

`default_nettype wire

// ----- bench/debounce_checker.sv -----
`timescale 1ns / 1ps

// Watches the tick, result and register channels, keeps its own copy of the
// debouncer state and compares every result word with the predicted one.
module debounce_checker #(
    parameter int unsigned HISTORY_DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ibd_tick_if                        tick,
    ibd_result_if                      result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int unsigned                fail_count,
    output int unsigned                words_pending
);
    import ibd_pkg::*;

    typedef struct packed {
        logic [1:0]  switch_status;
        logic        scanned;
        logic [7:0]  level_now;
        logic [31:0] press_time_ms;
        logic [31:0] release_time_ms;
        logic [2:0]  ring_next;
        logic [31:0] slot_press_ms;
        logic [31:0] slot_release_ms;
    } debounce_word_t;

    // register copies, held as int so the saturation sums stay signed
    int          step_cfg;
    logic        press_level;
    int          floor_cfg;
    int          ceiling_cfg;
    int          rise_cfg;
    int          fall_cfg;
    int          interval_cfg;

    int          level;
    logic [1:0]  status;
    logic [31:0] last_scan;
    logic [31:0] last_press;
    logic [31:0] last_release;
    int          ring_pos;
    logic [31:0] ring_press [HISTORY_DEPTH];
    logic [31:0] ring_release [HISTORY_DEPTH];

    debounce_word_t expected_words[$];

    function automatic debounce_word_t debounce_tick(input logic [31:0] now,
                                                     input logic pin,
                                                     input logic [2:0] slot);
        debounce_word_t w;
        logic [31:0]    elapsed;
        elapsed = now - last_scan;  // wraps modulo 2^32
        w.scanned = elapsed > interval_cfg;
        if (w.scanned) begin
            last_scan = now;
            if (pin == press_level) begin
                level += step_cfg;
                if (level > ceiling_cfg)
                    level = ceiling_cfg;
            end else begin
                level -= step_cfg;
                if (level < floor_cfg)
                    level = floor_cfg;
            end
            if (status != ST_ON && level > rise_cfg) begin
                status = ST_ON;
                last_press = now;
                ring_press[ring_pos] = now;
            end else if (status == ST_ON && level < fall_cfg) begin
                status = ST_OFF;
                last_release = now;
                ring_release[ring_pos] = now;
                ring_pos = (ring_pos + 1) % HISTORY_DEPTH;
                ring_press[ring_pos] = '0;
                ring_release[ring_pos] = '0;
            end
        end
        w.switch_status   = status;
        w.level_now       = level[7:0];
        w.press_time_ms   = last_press;
        w.release_time_ms = last_release;
        w.ring_next       = ring_pos[2:0];
        if (slot < HISTORY_DEPTH) begin
            w.slot_press_ms   = ring_press[slot];
            w.slot_release_ms = ring_release[slot];
        end else begin
            w.slot_press_ms   = '0;
            w.slot_release_ms = '0;
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        debounce_word_t want;
        logic [6:0]     raw_step;
        int             i;
        if (!rst_n) begin
            step_cfg     = 16;
            press_level  = 1'b0;
            floor_cfg    = 0;
            ceiling_cfg  = 160;
            rise_cfg     = 120;
            fall_cfg     = 40;
            interval_cfg = 8;
            level        = 0;
            status       = ST_UNKNOWN;
            last_scan    = '0;
            last_press   = '0;
            last_release = '0;
            ring_pos     = 0;
            for (i = 0; i < HISTORY_DEPTH; i++) begin
                ring_press[i]   = '0;
                ring_release[i] = '0;
            end
            expected_words.delete();
        end else begin
            // result first: a word accepted this edge cannot belong to this edge's tick
            if (result.valid && result.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no tick waiting for it");
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("switch_status", want.switch_status, result.switch_status);
                    check_field("scanned", want.scanned, result.scanned);
                    check_field("level_now", want.level_now, result.level_now);
                    check_field("press_time_ms", want.press_time_ms, result.press_time_ms);
                    check_field("release_time_ms", want.release_time_ms,
                                result.release_time_ms);
                    check_field("ring_next", want.ring_next, result.ring_next);
                    check_field("slot_press_ms", want.slot_press_ms, result.slot_press_ms);
                    check_field("slot_release_ms", want.slot_release_ms,
                                result.slot_release_ms);
                end
            end
            if (tick.valid && tick.ready)
                expected_words.push_back(debounce_tick(tick.now_ms, tick.pin_level,
                                                       tick.history_slot));
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_STEP_SIZE: begin
                        raw_step = pwdata[6:0];
                        step_cfg = (raw_step < STEP_MIN) ? STEP_MIN :
                                   (raw_step > STEP_MAX) ? STEP_MAX : raw_step;
                    end
                    REG_ACTIVE_HIGH:    press_level  = pwdata[0];
                    REG_LEVEL_FLOOR:    floor_cfg    = pwdata[7:0];
                    REG_LEVEL_CEILING:  ceiling_cfg  = pwdata[7:0];
                    REG_RISE_THRESHOLD: rise_cfg     = pwdata[7:0];
                    REG_FALL_THRESHOLD: fall_cfg     = pwdata[7:0];
                    REG_SCAN_INTERVAL:  interval_cfg = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        words_pending = expected_words.size();
    end

endmodule

// ----- bench/tb_integrating_button_debouncer.sv -----
`timescale 1ns / 1ps

module tb_integrating_button_debouncer;
    import ibd_pkg::*;

    localparam int unsigned HISTORY_DEPTH   = 8;
    localparam int unsigned PHASES          = 10;
    localparam int unsigned WORDS_PER_PHASE = 100;
    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam logic [2:0]  REG_SPARE       = 3'd7;  // no register behind it

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned fail_count;
    int unsigned words_pending;
    int unsigned cycles;

    // stimulus state
    logic [31:0] clock_ms;
    logic        pin_held;
    int unsigned run_left;
    int unsigned sent;
    bit          tick_calm;
    int unsigned gap_span;

    ibd_tick_if   tick_ch();
    ibd_result_if result_ch();

    integrating_button_debouncer #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    debounce_checker #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_debounce_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick_ch),
        .result        (result_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always #1 clk = ~clk;

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL integrating_button_debouncer");
        $finish;
    end

    // result side: random stalls, with calm stretches of no stall at all
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        taken = 0;
        calm  = 1'b0;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            taken++;
        end
    end

    task automatic send_tick(input logic [31:0] now, input logic pin, input logic [2:0] slot);
        int unsigned gap;
        if (sent % 64 == 0)
            tick_calm = ($urandom_range(0, 3) == 0);
        gap = tick_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.now_ms       <= now;
        tick_ch.pin_level    <= pin;
        tick_ch.history_slot <= slot;
        do @(posedge clk); while (!tick_ch.ready);
        sent++;
    endtask

    // setup then access; upper data bits are junk the block must mask off
    task automatic cfg_write(input logic [2:0] index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {24'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_words();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (4) @(posedge clk);  // let the pipe settle
    endtask

    task automatic apply_setting(input int unsigned phase);
        logic [7:0] step_raw;
        logic       hi;
        logic [7:0] floor_v;
        logic [7:0] ceil_v;
        logic [7:0] rise_v;
        logic [7:0] fall_v;
        logic [7:0] scan_v;
        case (phase)
            0:
            begin
                // smallest step, no interval, always-switching thresholds
                step_raw = 8'd0;   hi = 1'b1;     floor_v = 8'd0;  ceil_v = 8'd255;
                rise_v   = 8'd0;   fall_v = 8'd255; scan_v = 8'd0;
            end
            1:
            begin
                // largest step and interval, floor above ceiling
                step_raw = 8'd127; hi = 1'b0;     floor_v = 8'd255; ceil_v = 8'd0;
                rise_v   = 8'd255; fall_v = 8'd0;   scan_v = 8'd255;
            end
            2:
            begin
                step_raw = 8'd64;  hi = 1'b1;     floor_v = 8'd0;  ceil_v = 8'd255;
                rise_v   = 8'd200; fall_v = 8'd50;  scan_v = 8'd3;
            end
            default:
            begin
                step_raw = $urandom_range(0, 127);
                hi       = $urandom_range(0, 1);
                if ($urandom_range(0, 3) == 0)
                begin
                    floor_v = $urandom();
                    ceil_v  = $urandom();
                    rise_v  = $urandom();
                    fall_v  = $urandom();
                    scan_v  = $urandom();
                end
                else
                begin
                    floor_v = $urandom_range(0, 60);
                    ceil_v  = $urandom_range(140, 255);
                    rise_v  = $urandom_range(floor_v + 40, ceil_v - 20);
                    fall_v  = $urandom_range(floor_v + 5, rise_v - 10);
                    scan_v  = $urandom_range(0, 20);
                end
            end
        endcase
        cfg_write(REG_STEP_SIZE, step_raw);
        cfg_write(REG_ACTIVE_HIGH, {7'($urandom()), hi});
        cfg_write(REG_LEVEL_FLOOR, floor_v);
        cfg_write(REG_LEVEL_CEILING, ceil_v);
        cfg_write(REG_RISE_THRESHOLD, rise_v);
        cfg_write(REG_FALL_THRESHOLD, fall_v);
        cfg_write(REG_SCAN_INTERVAL, scan_v);
        cfg_write(REG_SPARE, 8'($urandom()));
        gap_span = scan_v;
    endtask

    // presses and releases of random length, with bounce and the odd time jump
    task automatic random_ticks(input int unsigned count);
        logic        pin;
        int unsigned k;
        for (k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                pin_held = ~pin_held;
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                       : $urandom_range(10, 60);
            end
            run_left--;
            pin = pin_held ^ ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, 2 * gap_span + 2);
            send_tick(clock_ms, pin, 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int          i;
        logic [31:0] t;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        tick_ch.valid        <= 1'b0;
        tick_ch.now_ms       <= '0;
        tick_ch.pin_level    <= 1'b0;
        tick_ch.history_slot <= '0;
        pin_held  = 1'b0;
        run_left  = 0;
        sent      = 0;
        tick_calm = 1'b0;
        clock_ms  = '0;
        gap_span  = 8;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: low pin means pressed, interval 8
        send_tick(32'd0, 1'b0, 3'd0);   // time has not moved
        send_tick(32'd8, 1'b0, 3'd1);   // exactly the interval, still no scan
        t = 32'd8;
        for (i = 0; i < 10; i++)
        begin
            t += 9;
            send_tick(t, 1'b0, i[2:0]);  // out of unknown, on, then into the ceiling
        end
        send_tick(t, 1'b1, 3'd0);
        for (i = 0; i < 8; i++)
        begin
            t += 9;
            send_tick(t, 1'b1, i[2:0]);  // down through the fall threshold
        end
        send_tick(32'hFFFF_FFF0, 1'b0, 3'd7);
        send_tick(32'h0000_0005, 1'b0, 3'd1);  // elapsed time across the wrap
        clock_ms = 32'h0000_0005;

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_words();
            apply_setting(phase);
            random_ticks(WORDS_PER_PHASE);
        end
        drain_words();

        if (fail_count == 0)
            $display("PASS integrating_button_debouncer");
        else
            $display("FAIL integrating_button_debouncer");
        $finish;
    end

endmodule
